// ===== hdl/seeded_mix_hash_bucket_defines.svh =====
// Assertion macros for the seeded mix hash bucket block.
`ifndef SEEDED_MIX_HASH_BUCKET_DEFINES_SVH
`define SEEDED_MIX_HASH_BUCKET_DEFINES_SVH

// Check a same-cycle implication, sampled on aclk, off during reset.
`define SMHB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication, sampled on aclk, off during reset.
`define SMHB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smhb_pkg.sv =====
// Shared types, constants and mix shift table for the seeded mix hash bucket block.
package smhb_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MIX_STEPS = 9;
    localparam int unsigned ADDR_W    = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_HASH_SEED    = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    // Which mix word a step updates.
    localparam int unsigned ROLE_A = 0;
    localparam int unsigned ROLE_B = 1;
    localparam int unsigned ROLE_C = 2;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t wa;
        word_t wb;
        word_t wc;
    } mix_t;

    typedef struct packed {
        word_t rem;
        word_t word;
    } div_t;

    // Shift amount of each of the nine mix steps.
    function automatic int unsigned mix_shift(input int unsigned step);
        int unsigned amount;
        case (step)
            0: amount = 13;
            1: amount = 8;
            2: amount = 13;
            3: amount = 12;
            4: amount = 16;
            5: amount = 5;
            6: amount = 3;
            7: amount = 10;
            8: amount = 15;
            default: amount = 0;
        endcase
        return amount;
    endfunction

endpackage

// ===== hdl/smhb_mix_cell.sv =====
// One mix step: updates one of the three mix words and registers all three.
module smhb_mix_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  smhb_pkg::mix_t in_words,
    output logic          out_valid,
    output smhb_pkg::mix_t out_words
);
    import smhb_pkg::*;

    localparam int unsigned ROLE  = STEP % 3;
    localparam int unsigned SHIFT = mix_shift(STEP);

    logic   valid_reg;
    mix_t   words_reg;
    mix_t   words_next;

    always_comb begin
        words_next = in_words;
        case (ROLE)
            ROLE_A: begin
                words_next.wa = (in_words.wa - in_words.wb - in_words.wc)
                                ^ (in_words.wc >> SHIFT);
            end
            ROLE_B: begin
                words_next.wb = (in_words.wb - in_words.wc - in_words.wa)
                                ^ (in_words.wa << SHIFT);
            end
            ROLE_C: begin
                words_next.wc = (in_words.wc - in_words.wa - in_words.wb)
                                ^ (in_words.wb >> SHIFT);
            end
            default: begin
                words_next = in_words;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            words_reg <= words_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_words = words_reg;

endmodule

// ===== hdl/smhb_div_cell.sv =====
// One restoring-division step: brings in one dividend bit and reduces the remainder.
module smhb_div_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  smhb_pkg::word_t divisor,
    input  logic           in_valid,
    input  smhb_pkg::div_t in_data,
    output logic           out_valid,
    output smhb_pkg::div_t out_data
);
    import smhb_pkg::*;

    logic              valid_reg;
    div_t              data_reg;
    div_t              data_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   divisor_ext;
    logic [WORD_W:0]   diff;

    always_comb begin
        trial       = {in_data.rem, in_data.word[BIT]};
        divisor_ext = {1'b0, divisor};
        diff        = trial - divisor_ext;
        data_next.word = in_data.word;
        if (trial >= divisor_ext) begin
            data_next.rem = diff[WORD_W-1:0];
        end else begin
            data_next.rem = trial[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/seeded_mix_hash_bucket.sv =====
// Top level of the seeded mix hash bucket block: config port, cell chain, output skid.
`include "seeded_mix_hash_bucket_defines.svh"

// Seeded mix hash bucket. Each key transaction on the s_ channel is hashed
// with the three-round 96-bit subtract/xor/shift mix (first word = hash_seed,
// second = 0, third = key) and returns one transaction on the m_ channel with
// the final third word (m_mixed_word) and that word modulo bucket_count
// (m_bucket). The datapath is a chain of 41 cells, nine mix steps followed by
// 32 one-bit restoring-division steps, all advancing together; a new key
// enters every cycle while the skid is empty, and its result passes through
// every cell and then the output register before it appears on m_valid.
// Throughput is one transaction per cycle while the skid is empty; when
// m_ready is held low a two-entry output (register plus skid)
// absorbs the in-flight result, and the chain then holds for as long as the
// skid stays full. Registers: hash_seed at byte address 0, bucket_count at
// byte address 4 (a write of zero to bucket_count is dropped). Change the
// registers only while no transaction is in flight.
module seeded_mix_hash_bucket (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smhb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // key channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_item_key,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_bucket,
    output logic [31:0]                   m_mixed_word
);
    import smhb_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    word_t hash_seed_reg;
    word_t bucket_count_reg;
    logic  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_seed_reg    <= '0;
            bucket_count_reg <= word_t'(1);
        end else if (cfg_write) begin
            case (paddr[2])
                REG_HASH_SEED: begin
                    hash_seed_reg <= pwdata;
                end
                REG_BUCKET_COUNT: begin
                    // drop a zero divisor, keep the old count
                    if (pwdata != '0) begin
                        bucket_count_reg <= pwdata;
                    end
                end
                default: begin
                    hash_seed_reg <= hash_seed_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HASH_SEED:    prdata = hash_seed_reg;
            REG_BUCKET_COUNT: prdata = bucket_count_reg;
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Cell chain: every cell advances when the skid stage is empty
    // ------------------------------------------------------------------
    logic  chain_en;
    logic  mix_valid [0:MIX_STEPS];
    mix_t  mix_words [0:MIX_STEPS];
    logic  div_valid [0:WORD_W];
    div_t  div_data  [0:WORD_W];

    logic  out_valid_reg;
    div_t  out_data_reg;
    logic  skid_valid_reg;
    div_t  skid_data_reg;

    assign chain_en = !skid_valid_reg;
    assign s_ready  = chain_en;

    // load the seed, zero and key as the three mix words
    assign mix_valid[0]    = s_valid;
    assign mix_words[0].wa = hash_seed_reg;
    assign mix_words[0].wb = '0;
    assign mix_words[0].wc = s_item_key;

    for (genvar step = 0; step < MIX_STEPS; step++) begin : g_mix
        smhb_mix_cell #(
            .STEP (step)
        ) u_mix (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (chain_en),
            .in_valid  (mix_valid[step]),
            .in_words  (mix_words[step]),
            .out_valid (mix_valid[step+1]),
            .out_words (mix_words[step+1])
        );
    end

    // start the division with a zero remainder and the mixed word as dividend
    assign div_valid[0]     = mix_valid[MIX_STEPS];
    assign div_data[0].rem  = '0;
    assign div_data[0].word = mix_words[MIX_STEPS].wc;

    // bucket_count must stay stable while transactions are in flight; the block itself does not enforce it
    for (genvar k = 0; k < WORD_W; k++) begin : g_div
        smhb_div_cell #(
            .BIT (WORD_W - 1 - k)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (chain_en),
            .divisor   (bucket_count_reg),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register plus skid: take the chain's last result while the
    // current one waits, then hold the chain until the skid drains
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= div_valid[WORD_W];
            end
        end else if (chain_en && div_valid[WORD_W]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= div_data[WORD_W];
            end
        end else if (chain_en) begin
            skid_data_reg <= div_data[WORD_W];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_bucket     = out_data_reg.rem;
    assign m_mixed_word = out_data_reg.word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SMHB_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `SMHB_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_ready, skid_valid_reg, "skid lost a result")
    `SMHB_ASSERT_SAME(a_bucket_range, m_valid, m_bucket < bucket_count_reg, "bucket out of range")
    `SMHB_ASSERT_SAME(a_divisor_nonzero, 1'b1, bucket_count_reg != '0, "bucket count is zero")

endmodule

// ===== tb/tb_seeded_mix_hash_bucket.sv =====
// Self-checking testbench for the seeded mix hash bucket: keys in, predicted buckets checked out.
`timescale 1ns / 100ps

module tb_seeded_mix_hash_bucket;
    import smhb_pkg::*;

    // Byte addresses of the two registers, built from the package indexes.
    localparam logic [ADDR_W-1:0] ADDR_HASH_SEED    = {REG_HASH_SEED, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_BUCKET_COUNT = {REG_BUCKET_COUNT, 2'b00};

    // Cycles with no transaction at all before the run is declared hung.
    localparam int WATCHDOG_LIMIT   = 2000;
    // Idle time at the end, after the last result, for any stray result to surface.
    localparam int SETTLE_CYCLES    = 60;
    // One long result-side hold-off, well past the block's buffering.
    localparam int LONG_HOLD_CYCLES = 400;

    // Holds a private copy of both registers, predicts the mix word and
    // bucket of every accepted key, and compares results in order.
    class hash_scoreboard;
        word_t seed_reg;
        word_t count_reg;
        div_t  pending_hashes[$];
        int    keys_noted;
        int    results_checked;
        int    errors;

        function new();
            seed_reg        = '0;
            count_reg       = 32'd1;
            keys_noted      = 0;
            results_checked = 0;
            errors          = 0;
        endfunction

        // A zero bucket count never takes effect.
        function void apply_write(logic index, word_t value);
            if (index == REG_HASH_SEED) begin
                seed_reg = value;
            end else if (value != '0) begin
                count_reg = value;
            end
        endfunction

        // Three rounds of subtract/xor/shift over seed, zero and key.
        function div_t hash_key(word_t key);
            word_t wa;
            word_t wb;
            word_t wc;
            div_t  res;
            wa = seed_reg;
            wb = '0;
            wc = key;
            wa = wa - wb - wc; wa = wa ^ (wc >> 13);
            wb = wb - wc - wa; wb = wb ^ (wa << 8);
            wc = wc - wa - wb; wc = wc ^ (wb >> 13);
            wa = wa - wb - wc; wa = wa ^ (wc >> 12);
            wb = wb - wc - wa; wb = wb ^ (wa << 16);
            wc = wc - wa - wb; wc = wc ^ (wb >> 5);
            wa = wa - wb - wc; wa = wa ^ (wc >> 3);
            wb = wb - wc - wa; wb = wb ^ (wa << 10);
            wc = wc - wa - wb; wc = wc ^ (wb >> 15);
            res.word = wc;
            res.rem  = wc % count_reg;
            return res;
        endfunction

        function void note_key(word_t key);
            pending_hashes.insert(pending_hashes.size(), hash_key(key));
            keys_noted++;
        endfunction

        function void check_result(word_t bucket, word_t mixed);
            div_t want;
            if (pending_hashes.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: bucket %h mixed_word %h",
                         $time, bucket, mixed);
                return;
            end
            want = pending_hashes.pop_front();
            results_checked++;
            if (bucket !== want.rem) begin
                errors++;
                $display("%0t: bucket mismatch: expected %h actual %h", $time, want.rem, bucket);
            end
            if (mixed !== want.word) begin
                errors++;
                $display("%0t: mixed_word mismatch: expected %h actual %h",
                         $time, want.word, mixed);
            end
        endfunction

        function void check_readback(logic index, word_t value);
            word_t want;
            want = (index == REG_HASH_SEED) ? seed_reg : count_reg;
            if (value !== want) begin
                errors++;
                $display("%0t: register %0d readback: expected %h actual %h",
                         $time, index, want, value);
            end
        endfunction
    endclass

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [31:0]       s_item_key   = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [31:0]       m_bucket;
    logic [31:0]       m_mixed_word;

    hash_scoreboard board = new();

    int keys_in       = 0;   // accepted keys, updated by the monitor
    int stall_cycles  = 0;   // consecutive cycles with no transaction
    int config_writes = 0;
    bit long_hold_req = 1'b0;

    seeded_mix_hash_bucket dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item_key   (s_item_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bucket     (m_bucket),
        .m_mixed_word (m_mixed_word)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Monitor: sample both channels at the edge, before any of this edge's
    // updates land. Note each accepted key, check each accepted result, and
    // drop the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_key(s_item_key);
                keys_in <= keys_in + 1;
            end
            if (m_valid && m_ready) begin
                board.check_result(m_bucket, m_mixed_word);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no transaction for %0d cycles, %0d results pending",
                         $time, WATCHDOG_LIMIT, board.pending_hashes.size());
                $display("*** FAILED ***");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Bias keys toward the corners: small values, near all-ones, single bits.
    function automatic word_t rand_key();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 255);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random ready runs and stalls of random length. Once asked,
    // hold off for a long stretch so the pipeline backs up into s_ready.
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // Offer one key and hold it until accepted. Leave valid high so the
    // next key can follow back to back; lower it only for a gap.
    task automatic offer_key(input word_t key, input int gap);
        s_valid    <= 1'b1;
        s_item_key <= key;
        do @(posedge aclk); while (!s_ready);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending_hashes.size() != 0) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access completes.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input word_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.apply_write(addr[2], data);
        config_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output word_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_registers();
        word_t value;
        apb_read(ADDR_HASH_SEED, value);
        board.check_readback(REG_HASH_SEED, value);
        apb_read(ADDR_BUCKET_COUNT, value);
        board.check_readback(REG_BUCKET_COUNT, value);
    endtask

    // Main sequence: reset, directed corner keys under the reset and the
    // extreme settings, a dropped zero bucket count, then random phases that
    // each start from an empty pipeline with a fresh seed and bucket count.
    initial begin
        word_t corner_keys [7] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                                   32'h5555_5555};
        word_t bucket_plan [10] = '{32'd2, 32'd3, 32'd7, 32'h8000_0000, 32'd16,
                                    32'h8000_0001, 32'd1000, 32'hFFFF_FFFE, 32'd0,
                                    32'd1};
        word_t seed_val;
        word_t count_val;
        int    n_keys;

        // Hold reset, then release it once for the whole run.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_registers();

        // Reset settings: seed zero, one bucket, so every bucket is zero.
        foreach (corner_keys[i]) offer_key(corner_keys[i], pick_gap());
        drain_results();

        // Both registers at their top value.
        apb_write(ADDR_HASH_SEED, 32'hFFFF_FFFF);
        apb_write(ADDR_BUCKET_COUNT, 32'hFFFF_FFFF);
        check_registers();
        foreach (corner_keys[i]) offer_key(corner_keys[i], pick_gap());
        drain_results();

        // A zero bucket count must be dropped; the old divisor stays.
        apb_write(ADDR_BUCKET_COUNT, 32'h0000_0000);
        check_registers();
        offer_key(32'h0000_0000, 0);
        offer_key(32'hFFFF_FFFF, 0);

        for (int phase = 0; phase < 10; phase++) begin
            // Pause the sender until the pipeline is empty before reconfiguring.
            drain_results();
            seed_val  = (phase == 0) ? 32'h8000_0000 : $urandom();
            count_val = (phase == 8) ? $urandom_range(2, 100000) : bucket_plan[phase];
            apb_write(ADDR_HASH_SEED, seed_val);
            apb_write(ADDR_BUCKET_COUNT, count_val);
            check_registers();
            n_keys = 58;
            if (phase == 3) begin
                // Keep offering through the long hold-off so s_ready drops.
                long_hold_req <= 1'b1;
                n_keys = 120;
            end
            repeat (n_keys) offer_key(rand_key(), pick_gap());
        end

        drain_results();
        // Let any stray result surface before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Hashed %0d keys across %0d register writes; %0d results compared",
                 board.keys_noted, config_writes, board.results_checked);
        $display("Settings spanned seeds 0 to all-ones and bucket counts 1 to 2^32-1.");
        if (board.errors == 0 && board.pending_hashes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
